>>> hdl/plic_pkg.sv
// Package for the priority level interrupt controller core.
// Holds action and status codes, field widths and the shortcut vector table.
// No dependencies.
package plic_pkg;

    localparam int ACT_W       = 2;
    localparam int VEC_W       = 7;
    localparam int LVL_W       = 3;
    localparam int BASIC_W     = 21;
    localparam int BANK_W      = 32;
    localparam int VEC_SLOTS   = 96;
    localparam int STACK_DEPTH = 8;
    localparam int SP_W        = 3;
    localparam int DEPTH_W     = 4;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 112;
    localparam int OUT_USER_W  = 3;
    localparam int BANK1_SEL   = 8;
    localparam int BANK2_SEL   = 9;
    localparam int SHORT_FIRST = 10;

    typedef enum logic [ACT_W-1:0] {
        ACT_UNMASK   = 2'd0,
        ACT_MASK     = 2'd1,
        ACT_DISPATCH = 2'd2,
        ACT_EOS      = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Result of the pending decode.
    typedef struct packed {
        logic             found;
        logic [VEC_W-1:0] vector;
    } dec_t;

    // Basic pending bits 10..20 route straight to these vectors.
    function automatic logic [VEC_W-1:0] shortcut_vec(input logic [3:0] idx);
        logic [VEC_W-1:0] v;
        case (idx)
            4'd0:    v = 7'd39;
            4'd1:    v = 7'd41;
            4'd2:    v = 7'd42;
            4'd3:    v = 7'd50;
            4'd4:    v = 7'd51;
            4'd5:    v = 7'd85;
            4'd6:    v = 7'd86;
            4'd7:    v = 7'd87;
            4'd8:    v = 7'd88;
            4'd9:    v = 7'd89;
            4'd10:   v = 7'd94;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/plic_pend_dec.sv
// Pending word decoder: lowest set bit of the basic word, bank words and shortcuts.
// Depends on plic_pkg.
module plic_pend_dec (
    input  logic [plic_pkg::BASIC_W-1:0] pending_basic,
    input  logic [plic_pkg::BANK_W-1:0]  pending_bank1,
    input  logic [plic_pkg::BANK_W-1:0]  pending_bank2,
    output plic_pkg::dec_t               dec
);
    import plic_pkg::*;

    logic                     basic_any;
    logic [4:0]               basic_idx;
    logic                     bank1_any;
    logic [4:0]               bank1_idx;
    logic                     bank2_any;
    logic [4:0]               bank2_idx;

    // Priority encoders: scan high to low so the lowest set bit wins.
    always_comb
    begin
        basic_any = 1'b0;
        basic_idx = '0;
        for (int i = BASIC_W - 1; i >= 0; i--)
        begin
            if (pending_basic[i])
            begin
                basic_any = 1'b1;
                basic_idx = 5'(i);
            end
        end
    end

    always_comb
    begin
        bank1_any = 1'b0;
        bank1_idx = '0;
        bank2_any = 1'b0;
        bank2_idx = '0;
        for (int i = BANK_W - 1; i >= 0; i--)
        begin
            if (pending_bank1[i])
            begin
                bank1_any = 1'b1;
                bank1_idx = 5'(i);
            end
            if (pending_bank2[i])
            begin
                bank2_any = 1'b1;
                bank2_idx = 5'(i);
            end
        end
    end

    always_comb
    begin
        dec.found  = basic_any;
        dec.vector = '0;
        if (basic_idx == 5'(BANK1_SEL))
        begin
            dec.found  = bank1_any;
            dec.vector = {2'b01, bank1_idx};
        end
        else if (basic_idx == 5'(BANK2_SEL))
        begin
            dec.found  = bank2_any;
            dec.vector = {2'b10, bank2_idx};
        end
        else if (basic_idx >= 5'(SHORT_FIRST))
        begin
            dec.vector = shortcut_vec(4'(basic_idx - 5'(SHORT_FIRST)));
        end
        else
        begin
            dec.vector = {2'b00, basic_idx};
        end
    end

endmodule

>>> hdl/priority_level_interrupt_controller_core.sv
// Top level of the priority level interrupt controller core.
// Depends on plic_pkg and plic_pend_dec.
//
// Channel  Dir  tdata (low bit up)                                      tuser
// s_*      in   vector_in 7, level_in 3, pending_basic 21,              action 2
//               pending_bank1 32, pending_bank2 32, pad 1
// m_*      out  vector_out 7, level_out 3, enable_basic 32,             status 2, spurious 1
//               enable_bank1 32, enable_bank2 32, pad 6
//
// One word per cycle while m_* is not stalled; a word taken on s_* passes through the
// input register and then the result register before it shows on m_*.
// Each word is latched into an input register, then one combinational pass decodes
// it, updates the level table, the current level and the level stack, and loads
// the result register. Reset clears the level table, current level, stack depth
// and both valid flags at once; the stack entries are written before being read.
// A stall on m_* holds the result register; the input register still drains
// into it once it empties, so s_tready drops only when both registers are full.
module priority_level_interrupt_controller_core #(
    parameter int NUM_VECTORS = 96,
    parameter int NUM_LEVELS  = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // vector_in[6:0], level_in[9:7], pending_basic[30:10],
    // pending_bank1[62:31], pending_bank2[94:63], zero[95]
    input  logic [plic_pkg::IN_DATA_W-1:0]     s_tdata,
    // action[1:0]
    input  logic [plic_pkg::ACT_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // vector_out[6:0], level_out[9:7], enable_basic[41:10],
    // enable_bank1[73:42], enable_bank2[105:74], zero[111:106]
    output logic [plic_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status[1:0], spurious[2]
    output logic [plic_pkg::OUT_USER_W-1:0]    m_tuser
);
    import plic_pkg::*;

    localparam int         IDX_W     = $clog2(NUM_VECTORS);
    localparam logic [3:0] LEVEL_MAX = 4'(NUM_LEVELS - 1);
    localparam logic [7:0] VEC_LIMIT = 8'(NUM_VECTORS);

    // Input register.
    logic                   in_valid_reg;
    action_t                in_act_reg;
    logic [VEC_W-1:0]       in_vec_reg;
    logic [LVL_W-1:0]       in_lvl_reg;
    logic [BASIC_W-1:0]     in_basic_reg;
    logic [BANK_W-1:0]      in_bank1_reg;
    logic [BANK_W-1:0]      in_bank2_reg;

    // Controller state.
    logic [LVL_W-1:0]       levels_reg [NUM_VECTORS];
    logic [LVL_W-1:0]       levels_next [NUM_VECTORS];
    logic [LVL_W-1:0]       cur_reg;
    logic [LVL_W-1:0]       cur_next;
    logic [DEPTH_W-1:0]     depth_reg;
    logic [DEPTH_W-1:0]     depth_next;
    logic [DEPTH_W-1:0]     depth_m1;
    logic [LVL_W-1:0]       stack_reg [STACK_DEPTH];
    logic                   push;

    // Result register.
    logic                   out_valid_reg;
    status_t                status_reg;
    status_t                status_next;
    logic [VEC_W-1:0]       vout_reg;
    logic [VEC_W-1:0]       vout_next;
    logic                   spur_reg;
    logic                   spur_next;
    logic [LVL_W-1:0]       lvl_out_reg;
    logic [VEC_SLOTS-1:0]   enable_reg;
    logic [VEC_SLOTS-1:0]   enable_next;

    logic                   advance;
    logic                   in_vec_ok;
    logic [LVL_W-1:0]       sat_lvl;
    dec_t                   dec;
    logic                   dec_vec_ok;
    logic [LVL_W-1:0]       dec_lvl;

    // Move the input word into the result register whenever that slot frees up.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_act_reg   <= action_t'(s_tuser);
            in_vec_reg   <= s_tdata[6:0];
            in_lvl_reg   <= s_tdata[9:7];
            in_basic_reg <= s_tdata[30:10];
            in_bank1_reg <= s_tdata[62:31];
            in_bank2_reg <= s_tdata[94:63];
        end
    end

    plic_pend_dec u_dec (
        .pending_basic (in_basic_reg),
        .pending_bank1 (in_bank1_reg),
        .pending_bank2 (in_bank2_reg),
        .dec           (dec)
    );

    // Ignore table writes beyond the vector count; clamp levels to the top level.
    assign in_vec_ok  = {1'b0, in_vec_reg} < VEC_LIMIT;
    assign sat_lvl    = ({1'b0, in_lvl_reg} > LEVEL_MAX) ? LEVEL_MAX[LVL_W-1:0] : in_lvl_reg;
    assign dec_vec_ok = {1'b0, dec.vector} < VEC_LIMIT;
    assign dec_lvl    = dec_vec_ok ? levels_reg[dec.vector[IDX_W-1:0]] : '0;
    assign depth_m1   = depth_reg - 1'b1;

    always_comb
    begin
        levels_next = levels_reg;
        cur_next    = cur_reg;
        depth_next  = depth_reg;
        push        = 1'b0;
        status_next = ST_OK;
        vout_next   = '0;
        spur_next   = 1'b0;
        unique case (in_act_reg)
            ACT_UNMASK:
            begin
                if (in_vec_ok)
                begin
                    levels_next[in_vec_reg[IDX_W-1:0]] = sat_lvl;
                end
            end
            ACT_MASK:
            begin
                if (in_vec_ok)
                begin
                    levels_next[in_vec_reg[IDX_W-1:0]] = '0;
                end
            end
            ACT_DISPATCH:
            begin
                if (!dec.found)
                begin
                    status_next = ST_NONE;
                end
                else if (depth_reg == DEPTH_W'(STACK_DEPTH))
                begin
                    // Stack full: report the vector, leave all state alone.
                    status_next = ST_FULL;
                    vout_next   = dec.vector;
                end
                else
                begin
                    vout_next  = dec.vector;
                    push       = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    if (dec_lvl > cur_reg)
                    begin
                        cur_next = dec_lvl;
                    end
                    else
                    begin
                        spur_next = 1'b1;
                    end
                end
            end
            ACT_EOS:
            begin
                if (depth_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    depth_next = depth_m1;
                    cur_next   = stack_reg[depth_m1[SP_W-1:0]];
                end
            end
        endcase
    end

    // Enable masks from the state as it stands after this word.
    always_comb
    begin
        enable_next = '0;
        for (int v = 0; v < NUM_VECTORS; v++)
        begin
            enable_next[v] = levels_next[v] > cur_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < NUM_VECTORS; v++)
            begin
                levels_reg[v] <= '0;
            end
            cur_reg   <= '0;
            depth_reg <= '0;
        end
        else if (advance)
        begin
            levels_reg <= levels_next;
            cur_reg    <= cur_next;
            depth_reg  <= depth_next;
        end
    end

    // Save the current level on the stack at each taken dispatch.
    always_ff @(posedge clk)
    begin
        if (advance && push)
        begin
            stack_reg[depth_reg[SP_W-1:0]] <= cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg  <= status_next;
            vout_reg    <= vout_next;
            spur_reg    <= spur_next;
            lvl_out_reg <= cur_next;
            enable_reg  <= enable_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, enable_reg, lvl_out_reg, vout_reg};
    assign m_tuser  = {spur_reg, status_reg};

endmodule

>>> hdl/plic_checker.sv
// Port-level checker for the priority level interrupt controller core, plus its bind.
// Depends on plic_pkg and priority_level_interrupt_controller_core.
module plic_checker #(
    parameter int NUM_VECTORS = 96
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [plic_pkg::IN_DATA_W-1:0]     s_tdata,
    input logic [plic_pkg::ACT_W-1:0]         s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [plic_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic [plic_pkg::OUT_USER_W-1:0]    m_tuser
);
    import plic_pkg::*;

    logic [VEC_SLOTS-1:0] enable_all;
    logic                 in_seen;

    assign enable_all = m_tdata[105:10];
    assign in_seen    = s_tvalid && s_tready && (s_tdata != '1 || s_tuser != '1);

    // Hold the result word while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // Nothing pending reports no vector and no spurious flag.
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == ST_NONE |-> m_tdata[6:0] == '0 && !m_tuser[2])
        else $error("nothing pending with vector or spurious set");

    // Spurious is only flagged on a dispatch that was taken.
    a_spur: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_OK)
        else $error("spurious with error status");

    // No enable bit above the vector count.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (enable_all >> NUM_VECTORS) == '0)
        else $error("enable bit beyond vector count");

    // A word can leave only after one entered.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(in_seen, 2)
            || $past(s_tvalid && s_tready, 3) || $past(s_tvalid, 2))
        else $error("result word without input word");

endmodule

bind priority_level_interrupt_controller_core plic_checker #(
    .NUM_VECTORS (NUM_VECTORS)
) u_plic_checker (.*);
